// ===== hw/rtl/icdr_pkg.sv =====
// Package for the int8 dot product / requantize block: constants and shared types.
`timescale 1ns / 1ps
package icdr_pkg;

  localparam int LANES_DEF     = 8;
  localparam int MAX_LANES     = 8;   // lanes the 64-bit slab fields can carry
  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam int ACC_W  = 32;
  localparam int MULT_W = 32;
  localparam int SHF_W  = 6;
  localparam int OUT_W  = 8;
  localparam int IDX_W  = 3;
  localparam int PRD_W  = 64;         // full-precision requantization datapath

  localparam logic [IDX_W-1:0] REG_SCALE_MULT = 3'd0;
  localparam logic [IDX_W-1:0] REG_SCALE_SHF  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ZP_OUT     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CLAMP_LO   = 3'd3;
  localparam logic [IDX_W-1:0] REG_CLAMP_HI   = 3'd4;

  localparam logic [PRD_W-1:0] RND_HALF = PRD_W'(64'd1 << 30);
  localparam int               Q_SHIFT  = 31;

  typedef struct packed {
    logic signed [MULT_W-1:0] scale_mult;
    logic signed [SHF_W-1:0]  scale_shift;
    logic signed [OUT_W-1:0]  zp_out;
    logic signed [OUT_W-1:0]  clamp_lo;
    logic signed [OUT_W-1:0]  clamp_hi;
  } cfg_t;

  // Finished accumulation handed from the front to the requantizer.
  typedef struct packed {
    logic                    push;
    logic signed [ACC_W-1:0] sum;
  } acc_req_t;

endpackage

// ===== hw/rtl/int8_conv_dot_requantize.sv =====
// Top level: int8 dot product with Q0.31 requantization, queue-style ports.
//
//  channel  handshake          payload
//  in       in_push / in_full  in_activations, in_weights, in_bias_value, in_last_slab
//  out      out_pop / out_empty out_result_value
//  cfg      cfg_wr_en          cfg_index, cfg_wdata
//
// The front takes one slab per cycle unless stalled; lane products are registered,
// then summed into the accumulator. A last slab's biased sum enters a short queue.
// The requantizer sequences one sum at a time through a 32x32 multiplier and takes no
// new sum until the previous result has left; the front stalls only on a last slab
// when that queue is full. Reset is synchronous, active low, and clears all control state.
`timescale 1ns / 1ps
module int8_conv_dot_requantize import icdr_pkg::*; #(
  parameter int LANES     = LANES_DEF,
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [63:0]             in_activations,
  input  logic [63:0]             in_weights,
  input  logic signed [ACC_W-1:0] in_bias_value,
  input  logic                    in_last_slab,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [OUT_W-1:0] out_result_value,
  input  logic                    cfg_wr_en,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [MULT_W-1:0]       cfg_wdata
);

  cfg_t              cfg_r;
  acc_req_t          mid_req;
  logic              mid_full, mid_empty, mid_pop;
  logic [ACC_W-1:0]  mid_rdata;
  logic              out_full, out_push;
  logic [OUT_W-1:0]  out_data, out_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_mult  <= 32'sh4000_0000;
      cfg_r.scale_shift <= '0;
      cfg_r.zp_out      <= '0;
      cfg_r.clamp_lo    <= -8'sd128;
      cfg_r.clamp_hi    <= 8'sd127;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SCALE_MULT: cfg_r.scale_mult  <= cfg_wdata;
        REG_SCALE_SHF:  cfg_r.scale_shift <= cfg_wdata[SHF_W-1:0];
        REG_ZP_OUT:     cfg_r.zp_out      <= cfg_wdata[OUT_W-1:0];
        REG_CLAMP_LO:   cfg_r.clamp_lo    <= cfg_wdata[OUT_W-1:0];
        REG_CLAMP_HI:   cfg_r.clamp_hi    <= cfg_wdata[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  icdr_front #(.LANES(LANES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_activations (in_activations),
    .in_weights     (in_weights),
    .in_bias_value  (in_bias_value),
    .in_last_slab   (in_last_slab),
    .mid_full       (mid_full),
    .mid_req        (mid_req)
  );

  icdr_queue #(.DEPTH(MID_DEPTH), .WIDTH(ACC_W)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_req.push),
    .wdata (mid_req.sum),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  icdr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_sum   ($signed(mid_rdata)),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_data)
  );

  icdr_queue #(.DEPTH(OUT_DEPTH), .WIDTH(OUT_W)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_data),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_result_value = $signed(out_rdata);

  // A finished sum must never be dropped at the middle queue.
  a_mid_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    mid_req.push |-> !mid_full)
    else $error("sum pushed into full middle queue");

  // A stalled slab stays in the front and is not lost.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |=> (u_front.s1_vld_r && u_front.s1_last_r))
    else $error("stalled last slab vanished");

  // The requantizer only takes a new sum once the previous result has left.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |=> !out_push)
    else $error("requantizer overlapped two sums");

endmodule

// ===== hw/rtl/icdr_queue.sv =====
// Small synchronous FIFO used between the stages of the block.
`timescale 1ns / 1ps
module icdr_queue #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/icdr_front.sv =====
// Front end: accepts slabs, registers lane products and keeps the running sum.
`timescale 1ns / 1ps
module icdr_front import icdr_pkg::*; #(
  parameter int LANES = LANES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [63:0]             in_activations,
  input  logic [63:0]             in_weights,
  input  logic signed [ACC_W-1:0] in_bias_value,
  input  logic                    in_last_slab,
  input  logic                    mid_full,
  output acc_req_t                mid_req
);

  // Lanes past the packed fields carry nothing.
  localparam int USED = (LANES < MAX_LANES) ? LANES : MAX_LANES;

  logic                    s1_vld_r;
  logic                    s1_last_r;
  logic signed [ACC_W-1:0] s1_bias_r;
  logic signed [15:0]      s1_prod_r [USED];
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W-1:0]        sum;
  logic                    stall, accept, fire;

  // Only a last slab needs room downstream.
  assign stall   = s1_vld_r & s1_last_r & mid_full;
  assign in_full = stall;
  assign accept  = in_push & ~stall;
  assign fire    = s1_vld_r & ~stall;

  always_comb begin
    sum = acc_r;
    for (int i = 0; i < USED; i++) begin
      sum = sum + {{(ACC_W-16){s1_prod_r[i][15]}}, s1_prod_r[i]};
    end
  end

  assign mid_req.push = fire & s1_last_r;
  assign mid_req.sum  = $signed(sum + ACC_W'(s1_bias_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      if (!stall) begin
        s1_vld_r <= accept;
      end
      if (fire) begin
        acc_r <= s1_last_r ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= in_last_slab;
      s1_bias_r <= in_bias_value;
      for (int i = 0; i < USED; i++) begin
        s1_prod_r[i] <= $signed(in_activations[8*i +: 8]) * $signed(in_weights[8*i +: 8]);
      end
    end
  end

endmodule

// ===== hw/rtl/icdr_back.sv =====
// Back end: sequenced Q0.31 requantization, offset and clamp of one sum at a time.
`timescale 1ns / 1ps
module icdr_back import icdr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    mid_empty,
  input  logic signed [ACC_W-1:0] mid_sum,
  output logic                    mid_pop,
  input  logic                    out_full,
  output logic                    out_push,
  output logic signed [OUT_W-1:0] out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_SHF,
    ST_FIN
  } state_t;

  state_t                  state_r;
  logic signed [ACC_W-1:0] x_r;
  logic signed [PRD_W-1:0] prod_r;
  logic signed [32:0]      scaled_r;
  logic signed [PRD_W-1:0] shv_r;

  logic signed [PRD_W-1:0] rnd_sum, scaled_ext, shv_nxt, zp_sum, clamped, lo_ext, hi_ext;
  logic [5:0]              neg_shf;
  logic [4:0]              r_amt, l_amt;
  logic                    shf_right;

  assign mid_pop  = (state_r == ST_IDLE) & ~mid_empty;
  assign out_push = (state_r == ST_FIN) & ~out_full;

  assign rnd_sum    = prod_r + $signed(RND_HALF);
  assign scaled_ext = {{(PRD_W-33){scaled_r[32]}}, scaled_r};

  always_comb begin
    shf_right = ~cfg.scale_shift[SHF_W-1] & (cfg.scale_shift != '0);
    r_amt     = cfg.scale_shift[4:0];
    neg_shf   = 6'(-cfg.scale_shift);
    // Shift of -32 is limited to 31; the clamp gives the same answer.
    l_amt     = neg_shf[5] ? 5'd31 : neg_shf[4:0];
    if (shf_right) begin
      shv_nxt = (scaled_ext + $signed(PRD_W'(64'd1) << (r_amt - 5'd1))) >>> r_amt;
    end else begin
      shv_nxt = scaled_ext <<< l_amt;
    end
  end

  always_comb begin
    zp_sum  = shv_r + PRD_W'(cfg.zp_out);
    lo_ext  = PRD_W'(cfg.clamp_lo);
    hi_ext  = PRD_W'(cfg.clamp_hi);
    clamped = (zp_sum < lo_ext) ? lo_ext : zp_sum;
    if (clamped > hi_ext) begin
      clamped = hi_ext;
    end
    out_data = clamped[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!mid_empty) begin
            x_r     <= mid_sum;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= PRD_W'(x_r) * PRD_W'(cfg.scale_mult);
          state_r <= ST_RND;
        end
        ST_RND: begin
          scaled_r <= rnd_sum[PRD_W-1:Q_SHIFT];
          state_r  <= ST_SHF;
        end
        ST_SHF: begin
          shv_r   <= shv_nxt;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // Hold the result until the output queue has room.
          if (!out_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the int8 dot product / Q0.31 requantize block.
`timescale 1ns / 1ps
module testbench;
  import icdr_pkg::*;

  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_SLABS   = 75;
  localparam int IDLE_PCT      = 13;
  localparam int REPORT_LIMIT  = 10;

  logic                    clk              = 1'b0;
  logic                    rst_n            = 1'b0;
  logic                    in_push          = 1'b0;
  logic                    in_full;
  logic [63:0]             in_activations   = '0;
  logic [63:0]             in_weights       = '0;
  logic signed [ACC_W-1:0] in_bias_value    = '0;
  logic                    in_last_slab     = 1'b0;
  logic                    out_empty;
  logic                    out_pop          = 1'b0;
  logic signed [OUT_W-1:0] out_result_value;
  logic                    cfg_wr_en        = 1'b0;
  logic [IDX_W-1:0]        cfg_index        = '0;
  logic [MULT_W-1:0]       cfg_wdata        = '0;

  bit quiet        = 1'b0;
  bit hold_request = 1'b0;
  int input_stalls = 0;
  int settings     = 0;

  int8_conv_dot_requantize DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_activations   (in_activations),
    .in_weights       (in_weights),
    .in_bias_value    (in_bias_value),
    .in_last_slab     (in_last_slab),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_result_value (out_result_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Predicts the int8 output of every finished dot product and holds them in order.
  class dot_scoreboard;
    int  scale_mult;
    int  scale_shift;
    int  zero_point;
    int  clamp_lo;
    int  clamp_hi;
    int  running_total;
    byte expected_values[$];
    int  mismatches;
    int  results_checked;
    int  slabs_taken;

    function new();
      scale_mult      = 32'h4000_0000;
      scale_shift     = 0;
      zero_point      = 0;
      clamp_lo        = -128;
      clamp_hi        = 127;
      running_total   = 0;
      mismatches      = 0;
      results_checked = 0;
      slabs_taken     = 0;
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_SCALE_MULT: scale_mult  = int'($signed(value));
        REG_SCALE_SHF:  scale_shift = int'($signed(value[SHF_W-1:0]));
        REG_ZP_OUT:     zero_point  = int'($signed(value[OUT_W-1:0]));
        REG_CLAMP_LO:   clamp_lo    = int'($signed(value[OUT_W-1:0]));
        REG_CLAMP_HI:   clamp_hi    = int'($signed(value[OUT_W-1:0]));
        default: ;
      endcase
    endfunction

    function byte requantize(int total);
      longint prod;
      longint scaled;
      int     amount;
      prod   = longint'(total) * longint'(scale_mult);
      scaled = (prod + (longint'(1) <<< 30)) >>> Q_SHIFT;
      if (scale_shift > 0) begin
        scaled = (scaled + (longint'(1) <<< (scale_shift - 1))) >>> scale_shift;
      end else begin
        amount = (-scale_shift > 31) ? 31 : -scale_shift;
        scaled = scaled * (longint'(1) <<< amount);
      end
      scaled = scaled + zero_point;
      // low bound first, so crossed bounds give the high one
      if (scaled < clamp_lo) scaled = clamp_lo;
      if (scaled > clamp_hi) scaled = clamp_hi;
      return byte'(scaled);
    endfunction

    function void note_request(logic [63:0] act, logic [63:0] wgt, logic [31:0] bias,
                               logic last);
      int total;
      int a;
      int w;
      total = running_total;
      slabs_taken++;
      for (int i = 0; i < LANES_DEF; i++) begin
        a     = $signed(act[8*i +: 8]);
        w     = $signed(wgt[8*i +: 8]);
        total = total + a * w;
      end
      if (!last) begin
        running_total = total;
        return;
      end
      total         = total + int'(bias);
      running_total = 0;
      expected_values.push_back(requantize(total));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] got);
      byte want;
      if (expected_values.size() == 0) begin
        flag($sformatf("mismatch: unexpected result %0d at %0t", got, $realtime));
        return;
      end
      want = expected_values.pop_front();
      results_checked++;
      if (got !== want)
        flag($sformatf("mismatch: result %0d expected %0d actual %0d at %0t",
                       results_checked, want, got, $realtime));
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  dot_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #400_000;
    $display("testbench: errors");
    $finish;
  end

  // Result side: pop at random, with one long hold-off on request.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_result(out_result_value);
      if (hold_request) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_pop <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_slab(input logic [63:0] act, input logic [63:0] wgt,
                           input logic [31:0] bias, input logic last);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_activations <= act;
    in_weights     <= wgt;
    in_bias_value  <= bias;
    in_last_slab   <= last;
    @(posedge clk);
    while (in_full) begin
      input_stalls++;
      @(posedge clk);
    end
    sb.note_request(act, wgt, bias, last);
  endtask

  // Let every queued request finish before touching registers.
  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input int mult, input int shift, input int zp,
                              input int lo, input int hi);
    logic [IDX_W-1:0] regs [5];
    logic [31:0]      vals [5];
    regs = '{REG_SCALE_MULT, REG_SCALE_SHF, REG_ZP_OUT, REG_CLAMP_LO, REG_CLAMP_HI};
    vals = '{mult, shift, zp, lo, hi};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_register(regs[i], vals[i]);
    end
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  task automatic random_config(input bit crossed);
    int mult;
    int shift;
    int zp;
    int lo;
    int hi;
    int swap;
    mult = $urandom;
    if ($urandom_range(0, 2) != 0) mult[31:30] = 2'b01;
    shift = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 63)) - 32
                                        : int'($urandom_range(6, 16));
    zp = int'($urandom_range(0, 255)) - 128;
    lo = int'($urandom_range(0, 255)) - 128;
    hi = int'($urandom_range(0, 255)) - 128;
    if ((lo > hi) != crossed) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    write_config(mult, shift, zp, lo, hi);
  endtask

  task automatic send_random_run(input int len);
    logic [63:0] act;
    logic [63:0] wgt;
    logic [31:0] bias;
    for (int k = 0; k < len; k++) begin
      act = {$urandom, $urandom};
      wgt = {$urandom, $urandom};
      // zero padding in the upper lanes
      if ($urandom_range(0, 4) == 0) act &= {64{1'b1}} >> (8 * $urandom_range(1, 7));
      case ($urandom_range(0, 7))
        0:       bias = $urandom;
        1, 2:    bias = '0;
        default: bias = $urandom_range(0, 131071) - 65536;
      endcase
      send_slab(act, wgt, bias, k == len - 1);
    end
  endtask

  task automatic run_directed();
    // reset settings: multiplier one half, no shift, full int8 range
    send_slab('0, '0, '0, 1'b1);
    send_slab({8{8'h7F}}, {8{8'h7F}}, '0, 1'b1);
    send_slab({8{8'h80}}, {8{8'h7F}}, '0, 1'b1);
    send_slab({8{8'h80}}, {8{8'h80}}, '0, 1'b1);
    send_slab(64'h01, 64'h01, '0, 1'b1);
    send_slab(64'h01, 64'hFF, '0, 1'b1);
    send_slab(64'h0807_0605_0403_0201, 64'hFFFE_FDFC_0403_0201, 32'd77, 1'b0);
    send_slab(64'h0000_0000_7F80_FF01, 64'h0000_0000_01FF_807F, 32'd123, 1'b0);
    send_slab(64'hA55A_3CC3_0FF0_9669, 64'h1234_5678_9ABC_DEF0, -32'sd300, 1'b1);
    // bias add wraps past the int32 limits
    send_slab({8{8'h7F}}, {8{8'h7F}}, 32'h7FFF_FFFF, 1'b1);
    send_slab({8{8'h80}}, {8{8'h7F}}, 32'h8000_0000, 1'b1);
    send_slab(64'h40, 64'h7F7F_7F7F_7F7F_7F02, '0, 1'b1);
    drain();

    // largest multiplier with a left shift of 32: any nonzero value saturates
    write_config(32'h7FFF_FFFF, -32, 0, -128, 127);
    send_slab(64'h01, 64'h01, '0, 1'b1);
    send_slab(64'h01, 64'hFF, '0, 1'b1);
    send_slab('0, '0, '0, 1'b1);
    drain();

    // most negative multiplier, largest right shift, top offset
    write_config(32'h8000_0000, 31, 127, -128, 127);
    send_slab('0, '0, 32'h7FFF_FFFF, 1'b1);
    send_slab('0, '0, 32'h8000_0000, 1'b1);
    send_slab({8{8'h80}}, {8{8'h80}}, 32'h4000_0000, 1'b0);
    send_slab('0, '0, '0, 1'b1);
    drain();

    // crossed clamp bounds, lowest offset
    write_config(0, -31, -128, 127, -128);
    send_slab({8{8'h7F}}, {8{8'h7F}}, '0, 1'b1);
    send_slab({8{8'h80}}, {8{8'h7F}}, 32'h1234_5678, 1'b1);
    drain();
  endtask

  initial begin
    int len;
    int phase_slabs;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 6; ph++) begin
      random_config($urandom_range(0, 9) == 0);
      quiet = (ph == 1);
      // starve the result side so the block fills and backs up its input
      if (ph == 3) hold_request = 1'b1;
      phase_slabs = 0;
      while (phase_slabs < PHASE_SLABS) begin
        if (ph == 3)                         len = $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0)  len = $urandom_range(7, 20);
        else                                 len = $urandom_range(1, 5);
        send_random_run(len);
        phase_slabs += len;
      end
      drain();
    end
    quiet = 1'b0;
    $display("run covered %0d slabs and %0d checked outputs over %0d register settings",
             sb.slabs_taken, sb.results_checked, settings);
    $display("input backed up for %0d cycles; %0d mismatches seen",
             input_stalls, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
